@@ rtl/cprng_pkg.sv @@
`timescale 1ns / 1ps

package cprng_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;

	localparam int DOUBLE_ROUNDS_DEF = 10;

	// Each double round is eight ARX steps: four for the column round, four for the
	// diagonal round.
	localparam int STEPS_PER_DR = 8;

	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	localparam word_t COUNTER_START = 32'd1;

	function automatic word_t rotl(input word_t v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Rotation distance of each of the four steps of a quarter round.
	function automatic int rot_amount(input int sub);
		int r;
		unique case (sub)
			0: r = 16;
			1: r = 12;
			2: r = 8;
			default: r = 7;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/cprng_ctr_src.sv @@
`timescale 1ns / 1ps

module cprng_ctr_src import cprng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        accept,
	input  logic        restart,
	output state_t      init_state
);

	logic [63:0] seed_q;
	word_t       counter_q;
	word_t       ctr_use;

	assign ctr_use = restart ? COUNTER_START : counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= '0;
			counter_q <= COUNTER_START;
		end else begin
			priority if (cfg_we) begin
				// Reseeding restarts the block counter.
				seed_q    <= cfg_wdata;
				counter_q <= COUNTER_START;
			end else if (accept) begin
				counter_q <= ctr_use + 32'd1;
			end
		end
	end

	always_comb begin
		init_state     = '0;
		init_state[0]  = SIGMA0;
		init_state[1]  = SIGMA1;
		init_state[2]  = SIGMA2;
		init_state[3]  = SIGMA3;
		init_state[4]  = seed_q[31:0];
		init_state[5]  = seed_q[63:32];
		init_state[12] = ctr_use;
	end

endmodule

@@ rtl/cprng_arx_cell.sv @@
`timescale 1ns / 1ps

module cprng_arx_cell import cprng_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	input  state_t up_state,
	output logic   up_ready,
	output logic   down_valid,
	output state_t down_state,
	input  logic   down_ready
);

	localparam int SUB  = STEP % 4;
	localparam int DIAG = (STEP / 4) % 2;
	localparam int ROT  = rot_amount(SUB);

	logic   valid_q;
	state_t state_q;
	state_t nxt;

	// One add-xor-rotate step applied to all four quarter rounds in parallel.
	always_comb begin
		int    ia;
		int    ib;
		int    ic;
		int    id;
		int    x;
		int    y;
		int    z;
		word_t s;
		nxt = up_state;
		for (int q = 0; q < 4; q++) begin
			ia = q;
			ib = 4 + ((q + DIAG) % 4);
			ic = 8 + ((q + 2 * DIAG) % 4);
			id = 12 + ((q + 3 * DIAG) % 4);
			x  = (SUB % 2 == 0) ? ia : ic;
			y  = (SUB % 2 == 0) ? ib : id;
			z  = (SUB % 2 == 0) ? id : ib;
			s  = up_state[x] + up_state[y];
			nxt[x] = s;
			nxt[z] = rotl(up_state[z] ^ s, ROT);
		end
	end

	assign up_ready = !valid_q || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			state_q <= nxt;
		end
	end

	assign down_valid = valid_q;
	assign down_state = state_q;

endmodule

@@ rtl/chacha20_counter_prng.sv @@
`timescale 1ns / 1ps

// ChaCha20 counter-mode random word generator. Every input beat requests one
// 32-bit random word, which is word zero of the ChaCha20 block output for the
// current block counter; the counter starts at 1, advances by one per beat, and
// wraps from all ones to zero without touching the nonce. A beat with restart
// set reloads the counter to 1 before use, and writing the 64-bit seed through
// cfg_we / cfg_wdata (low half into key word zero, high half into key word one)
// reloads it as well; write the seed only while no requests are in flight. The
// block takes one request per clock cycle and returns one result per cycle as
// long as out_ready stays high. The datapath is a chain of cells, each of which
// performs one add-xor-rotate step of all four quarter rounds and registers the
// full 512-bit state. Each cell moves its beat forward whenever the next cell
// is empty or moving, so a stalled output only fills the chain gradually and
// requests are still accepted while empty cells remain.
module chacha20_counter_prng import cprng_pkg::*; #(
	parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_word
);

	localparam int NSTEPS = STEPS_PER_DR * DOUBLE_ROUNDS;

	state_t link_state [NSTEPS + 1];
	logic   link_valid [NSTEPS + 1];
	logic   link_ready [NSTEPS + 1];

	// The counter source forms the starting matrix for the beat offered now.
	cprng_ctr_src u_src (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.accept     (in_valid && in_ready),
		.restart    (restart),
		.init_state (link_state[0])
	);

	assign link_valid[0] = in_valid;
	assign in_ready      = link_ready[0];

	// Cell i performs step i mod 8 of its double round.
	for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
		cprng_arx_cell #(
			.STEP (i % STEPS_PER_DR)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (link_valid[i]),
			.up_state   (link_state[i]),
			.up_ready   (link_ready[i]),
			.down_valid (link_valid[i + 1]),
			.down_state (link_state[i + 1]),
			.down_ready (link_ready[i + 1])
		);
	end

	// The last cell doubles as the output register; the feed-forward add of the
	// first constant is all that sits between it and the port.
	assign link_ready[NSTEPS] = out_ready;
	assign out_valid          = link_valid[NSTEPS];
	assign random_word        = link_state[NSTEPS][0] + SIGMA0;

endmodule

@@ tb/chacha20_counter_prng_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the ChaCha20 counter-mode word generator.
module chacha20_counter_prng_tb;
	import cprng_pkg::*;

	localparam int ROUNDS = DOUBLE_ROUNDS_DEF;
	// One ARX step per pipeline cell, so the chain holds this many cells.
	localparam int CHAIN_DEPTH = STEPS_PER_DR * ROUNDS;
	localparam int CLK_HALF = 6;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        restart;
	logic        out_valid;
	logic        out_ready;
	word_t       random_word;

	// Shadow copy of the generator state: the seed held in key words zero and one,
	// and the block counter that the next request will use.
	logic [63:0] gen_seed;
	word_t       gen_counter;

	// Words that the block still owes us, oldest first.
	word_t pending_words[$];

	int error_count;

	// Idle percentages for the request side and the result side.
	int send_idle_pct;
	int recv_idle_pct;

	chacha20_counter_prng DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_word(random_word)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#5_000_000;
		$display("chacha20_counter_prng_tb: done, errors");
		$finish;
	end

	// Rotate left built from a doubled word, so the wrapped bits fall out of
	// the upper half without any shift-by-32 corner case.
	function automatic word_t rot_left(input word_t v, input int n);
		logic [63:0] twice;
		twice = {v, v} << n;
		return twice[63:32];
	endfunction

	// One ChaCha quarter round on words a, b, c and d of the state.
	function automatic state_t quarter_mix(input state_t s, input int a, input int b,
			input int c, input int d);
		s[a] = s[a] + s[b]; s[d] = rot_left(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rot_left(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rot_left(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rot_left(s[b] ^ s[c], 7);
		return s;
	endfunction

	// Word zero of the keystream block for the given seed and counter. Only
	// word zero is returned, so the feed-forward add is just the first constant.
	function automatic word_t chacha_head_word(input logic [63:0] seed, input word_t ctr);
		state_t s;
		s = '0;
		s[0] = SIGMA0;
		s[1] = SIGMA1;
		s[2] = SIGMA2;
		s[3] = SIGMA3;
		s[4] = seed[31:0];
		s[5] = seed[63:32];
		s[12] = ctr;
		for (int r = 0; r < ROUNDS; r++) begin
			// Column round.
			s = quarter_mix(s, 0, 4, 8, 12);
			s = quarter_mix(s, 1, 5, 9, 13);
			s = quarter_mix(s, 2, 6, 10, 14);
			s = quarter_mix(s, 3, 7, 11, 15);
			// Diagonal round.
			s = quarter_mix(s, 0, 5, 10, 15);
			s = quarter_mix(s, 1, 6, 11, 12);
			s = quarter_mix(s, 2, 7, 8, 13);
			s = quarter_mix(s, 3, 4, 9, 14);
		end
		return s[0] + SIGMA0;
	endfunction

	// Result side: ready is redrawn every cycle, so stalls land on any phase
	// of the pipeline's progress, including while the chain is filling.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every accepted result beat is matched against the oldest word owed.
	// Values here are the ones that stood before this edge, so acceptance is
	// seen exactly as the block sees it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("random_word: no result expected, got %08h", random_word);
				error_count++;
			end else begin
				word_t want;
				want = pending_words.pop_front();
				if (random_word !== want) begin
					$error("random_word: expected %08h, got %08h", want, random_word);
					error_count++;
				end
			end
		end
	end

	// Sends one request beat and books the word it must produce. Valid is left
	// high on return so that back-to-back beats never drop it; an optional gap
	// before the beat lowers it first. The gap is drawn cycle by cycle, so the
	// sender idles in about send_idle_pct cycles of a hundred.
	task automatic request_word(input logic rs);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
		// Restart reloads the counter before it is used for this beat.
		if (rs)
			gen_counter = COUNTER_START;
		pending_words.push_back(chacha_head_word(gen_seed, gen_counter));
		gen_counter = gen_counter + 1'b1;
	endtask

	// Stops requesting and waits until every booked word has come back. Every
	// request yields exactly one word, so an empty queue means an empty chain.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	// Loads a new seed while the block is idle. Reseeding also restarts the
	// counter at one.
	task automatic load_seed(input logic [63:0] seed);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_seed = seed;
		gen_counter = COUNTER_START;
	endtask

	function automatic logic [63:0] random_seed();
		logic [63:0] s;
		case ($urandom_range(5))
			0: s = '0;
			1: s = '1;
			2: s = 64'h1 << $urandom_range(63);
			3: s = ~(64'h1 << $urandom_range(63));
			default: s = {$urandom(), $urandom()};
		endcase
		return s;
	endfunction

	// Straight out of reset the seed is zero and the counter is one, with no
	// configuration write at all.
	task automatic test_reset_state();
		repeat (4) request_word(1'b0);
	endtask

	// Seeds at the extremes, alternating bit patterns, and each half set on
	// its own to catch swapped key words.
	task automatic test_seed_extremes();
		load_seed(64'hFFFF_FFFF_FFFF_FFFF);
		repeat (3) request_word(1'b0);
		load_seed(64'h0000_0000_0000_0000);
		repeat (2) request_word(1'b0);
		load_seed(64'hAAAA_AAAA_5555_5555);
		repeat (2) request_word(1'b0);
		load_seed(64'h0000_0000_FFFF_FFFF);
		request_word(1'b0);
		load_seed(64'hFFFF_FFFF_0000_0000);
		request_word(1'b0);
	endtask

	// Restart in the middle of a run, twice in a row, and on the very first
	// beat after a reseed, where it must be a no-op.
	task automatic test_restart_flag();
		load_seed(64'h0123_4567_89AB_CDEF);
		request_word(1'b1);
		repeat (3) request_word(1'b0);
		request_word(1'b1);
		request_word(1'b1);
		repeat (2) request_word(1'b0);
	endtask

	// Writing the same seed again must still pull the counter back to one.
	task automatic test_reseed_reloads_counter();
		repeat (4) request_word(1'b0);
		load_seed(gen_seed);
		repeat (2) request_word(1'b0);
	endtask

	// Long counter runs with random content: mostly plain continuation beats,
	// an occasional restart, and a fresh seed every so often while idle. The
	// counter cannot get near its wrap point in a run of this length.
	task automatic test_random_stream(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 120 == 119)
				load_seed(random_seed());
			request_word($urandom_range(99) < 4);
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		out_ready = 1'b0;
		error_count = 0;
		send_idle_pct = 10;
		recv_idle_pct = 64;
		gen_seed = '0;
		gen_counter = COUNTER_START;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_seed_extremes();
		test_restart_flag();
		test_reseed_reloads_counter();

		// Slow consumer with a busy producer: the chain backs up under stalls.
		load_seed(random_seed());
		test_random_stream(480);

		// Sparse requests with a mostly ready consumer.
		send_idle_pct = 64;
		recv_idle_pct = 10;
		load_seed(random_seed());
		test_random_stream(480);

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_seed(random_seed());
		test_random_stream(490);

		// Let anything stray fall out of the chain before judging.
		repeat (CHAIN_DEPTH + 20) @(posedge clk);

		if (error_count == 0 && pending_words.size() == 0) begin
			$display("chacha20_counter_prng_tb: done, clean");
		end else begin
			$display("chacha20_counter_prng_tb: done, errors");
		end
		$finish;
	end

endmodule

@@ chacha20_counter_prng.f @@
rtl/cprng_pkg.sv
rtl/cprng_ctr_src.sv
rtl/cprng_arx_cell.sv
rtl/chacha20_counter_prng.sv
tb/chacha20_counter_prng_tb.sv
